FILE: rtl/lpe_pkg.sv
package lpe_pkg;

  // Extraction phases, in the order the embedded stream is laid out.
  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_KBITS   = 3'd2,
    PH_SKIP    = 3'd3,
    PH_DATA    = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  // Header field sizes, given as the last bit position of each field.
  localparam logic [5:0] VERSION_LAST = 6'd15;
  localparam logic [5:0] LENGTH_LAST  = 6'd31;
  localparam logic [5:0] KBITS_LAST   = 6'd2;

  // Field widths of the header and of the payload path.
  localparam int unsigned VERSION_W = 16;
  localparam int unsigned LENGTH_W  = 32;
  localparam int unsigned KBITS_W   = 3;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned PEND_W    = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KMAX_W    = 7;

  localparam logic [PEND_W-1:0] BYTE_BITS = 4'd8;

endpackage

FILE: rtl/lsb_payload_extract.sv
// Throughput: one coefficient per cycle while its beat gives no byte or the output register has
// room; the input register feeds a combinational update of the header and payload state, and an
// output register holds the byte until it is taken.
// Reset (rst_n low, synchronous) returns to the version phase and clears the header fields,
// bit counters, byte count and both valid flags.
module lsb_payload_extract #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COEF_WIDTH-1:0]         in_coefficient,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lpe_pkg::BYTE_W-1:0]           out_data_byte,
  output logic [lpe_pkg::LENGTH_W-1:0]         out_byte_index,
  output logic                                 out_last_byte,
  output logic [lpe_pkg::VERSION_W-1:0]        out_format_version
);

  // Input register.
  logic                           coef_valid_r;
  logic [COEF_WIDTH-1:0]          coef_r;

  // Extraction state.
  lpe_pkg::phase_t                phase_r, phase_nxt;
  logic [5:0]                     hcnt_r, hcnt_nxt;
  logic [lpe_pkg::VERSION_W-1:0]  version_r, version_nxt;
  logic [lpe_pkg::LENGTH_W-1:0]   length_r, length_nxt;
  logic [lpe_pkg::KBITS_W-1:0]    kbits_r, kbits_nxt;
  logic [lpe_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [lpe_pkg::PEND_W-1:0]     pend_r, pend_nxt;
  logic [lpe_pkg::LENGTH_W-1:0]   bytes_r, bytes_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic [lpe_pkg::BYTE_W-1:0]     data_byte_r, data_byte_nxt;
  logic [lpe_pkg::LENGTH_W-1:0]   byte_index_r;
  logic                           last_byte_r, last_byte_nxt;
  logic [lpe_pkg::VERSION_W-1:0]  version_out_r;

  // Step signals.
  logic                           coef_bit;
  logic                           coef_nz;
  logic [lpe_pkg::KMAX_W-1:0]     kmask;
  logic [lpe_pkg::KMAX_W-1:0]     new_bits;
  logic [lpe_pkg::PEND_W-1:0]     pend_sum;
  logic                           emit;
  logic                           out_free;
  logic                           advance;
  logic                           load_out;

  // Handshake: the input register moves on whenever its beat gives no byte or the
  // output register has room.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = coef_valid_r && (out_free || !emit);
  assign load_out = advance && emit;
  assign in_ready = !coef_valid_r || advance;

  // Low coefficient bits used by the header and payload phases.
  assign coef_bit = coef_r[0];
  assign coef_nz  = |coef_r;
  assign kmask    = ~({lpe_pkg::KMAX_W{1'b1}} << kbits_r);
  assign new_bits = coef_r[lpe_pkg::KMAX_W-1:0] & kmask;
  assign pend_sum = pend_r + lpe_pkg::PEND_W'(kbits_r);

  // Next-state logic for one coefficient; zero coefficients leave everything unchanged.
  always_comb begin
    phase_nxt     = phase_r;
    hcnt_nxt      = hcnt_r;
    version_nxt   = version_r;
    length_nxt    = length_r;
    kbits_nxt     = kbits_r;
    acc_nxt       = acc_r;
    pend_nxt      = pend_r;
    bytes_nxt     = bytes_r;
    emit          = 1'b0;
    data_byte_nxt = '0;
    last_byte_nxt = 1'b0;
    if (coef_nz) begin
      case (phase_r)
        lpe_pkg::PH_VERSION: begin
          version_nxt = version_r | (lpe_pkg::VERSION_W'(coef_bit) << hcnt_r[3:0]);
          if (hcnt_r == lpe_pkg::VERSION_LAST) begin
            hcnt_nxt  = '0;
            phase_nxt = lpe_pkg::PH_LENGTH;
          end else begin
            hcnt_nxt = hcnt_r + 6'd1;
          end
        end
        lpe_pkg::PH_LENGTH: begin
          length_nxt = length_r | (lpe_pkg::LENGTH_W'(coef_bit) << hcnt_r[4:0]);
          if (hcnt_r == lpe_pkg::LENGTH_LAST) begin
            hcnt_nxt  = '0;
            phase_nxt = lpe_pkg::PH_KBITS;
          end else begin
            hcnt_nxt = hcnt_r + 6'd1;
          end
        end
        lpe_pkg::PH_KBITS: begin
          kbits_nxt = kbits_r | (lpe_pkg::KBITS_W'(coef_bit) << hcnt_r[1:0]);
          if (hcnt_r == lpe_pkg::KBITS_LAST) begin
            hcnt_nxt  = '0;
            phase_nxt = lpe_pkg::PH_SKIP;
          end else begin
            hcnt_nxt = hcnt_r + 6'd1;
          end
        end
        lpe_pkg::PH_SKIP: begin
          phase_nxt = lpe_pkg::PH_DATA;
        end
        lpe_pkg::PH_DATA: begin
          if (bytes_r >= length_r) begin
            phase_nxt = lpe_pkg::PH_DONE;
          end else begin
            acc_nxt = (acc_r << kbits_r) | lpe_pkg::ACC_W'(new_bits);
            if (pend_sum >= lpe_pkg::BYTE_BITS) begin
              emit          = 1'b1;
              pend_nxt      = pend_sum - lpe_pkg::BYTE_BITS;
              bytes_nxt     = bytes_r + 32'd1;
              data_byte_nxt = lpe_pkg::BYTE_W'(acc_nxt >> pend_nxt);
              last_byte_nxt = (bytes_nxt == length_r);
            end else begin
              pend_nxt = pend_sum;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // Output valid flag.
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and header state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= lpe_pkg::PH_VERSION;
      hcnt_r       <= '0;
      version_r    <= '0;
      length_r     <= '0;
      kbits_r      <= '0;
      acc_r        <= lpe_pkg::ACC_W'(1);
      pend_r       <= '0;
      bytes_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_ready) begin
        coef_valid_r <= in_valid;
      end
      if (advance) begin
        phase_r   <= phase_nxt;
        hcnt_r    <= hcnt_nxt;
        version_r <= version_nxt;
        length_r  <= length_nxt;
        kbits_r   <= kbits_nxt;
        acc_r     <= acc_nxt;
        pend_r    <= pend_nxt;
        bytes_r   <= bytes_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      coef_r <= in_coefficient;
    end
    if (load_out) begin
      data_byte_r   <= data_byte_nxt;
      byte_index_r  <= bytes_r;
      last_byte_r   <= last_byte_nxt;
      version_out_r <= version_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = data_byte_r;
  assign out_byte_index     = byte_index_r;
  assign out_last_byte      = last_byte_r;
  assign out_format_version = version_out_r;

  // A byte is only produced while in the data phase.
  a_emit_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (phase_r == lpe_pkg::PH_DATA))
    else $error("byte produced outside the data phase");

  // Once done, no further byte is ever produced.
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lpe_pkg::PH_DONE) |-> !load_out)
    else $error("byte produced after completion");

  // Fewer than eight bits remain pending at all times, including after a byte is taken.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r < lpe_pkg::BYTE_BITS)
    else $error("pending bit count reached a full byte");

  // The last byte leaves the byte count equal to the payload length.
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_byte_nxt) |=> (bytes_r == length_r))
    else $error("last byte flagged with a byte count short of the length");

  // A beat waiting in the input register is never dropped while the output is full.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (coef_valid_r && !advance) |=> (coef_valid_r && $stable(coef_r)))
    else $error("stalled coefficient lost from the input register");

endmodule
